[design/qvr_pkg.sv]
package qvr_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // Divider: one quotient bit per stage, 32 quotient bits
   localparam int DIV_STAGES = 32;

   // Register map, word index = paddr[3:2]
   localparam logic [1:0] REG_AXIS_W = 2'd0;
   localparam logic [1:0] REG_AXIS_X = 2'd1;
   localparam logic [1:0] REG_AXIS_Y = 2'd2;
   localparam logic [1:0] REG_AXIS_Z = 2'd3;

   localparam logic [31:0] AXIS_W_RST = 32'h0001_0000;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   // Half-degree reduction: (angle + 32768 + ANGLE_OFS) is a multiple of 720 away
   localparam logic [16:0] ANGLE_OFS  = 17'd352;
   localparam logic [16:0] RECIP_720  = 17'd93206;   // floor(2^26 / 720)
   localparam int          RECIP_SHIFT = 26;
   localparam logic [16:0] MOD_720    = 17'd720;

   localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
   localparam logic [63:0] PI_360_Q30 = 64'd9370165;

   typedef logic [30:0] trig_tab_type [0:90];

   function automatic logic [63:0] sin_poly(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 30;
      t = ONE_Q30 - x2 / 64'd72;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      return (x * t) >> 30;
   endfunction

   function automatic logic [63:0] cos_poly(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = (x * x) >> 30;
      t = ONE_Q30 - x2 / 64'd56;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd30;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd12;
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'd2;
      return t;
   endfunction

   // Q30 sin or cos of r half-degrees, r = 0..90
   function automatic trig_tab_type build_tab(input logic want_cos);
      trig_tab_type tab;
      logic [63:0]  x;
      for (int r = 0; r <= 90; r++) begin
         x = 64'(r) * PI_360_Q30;
         tab[r] = want_cos ? 31'(cos_poly(x)) : 31'(sin_poly(x));
      end
      return tab;
   endfunction

   localparam trig_tab_type SIN_TAB = build_tab(1'b0);
   localparam trig_tab_type COS_TAB = build_tab(1'b1);

endpackage

[design/quaternion_vector_rotator.sv]
// Quaternion vector rotator.
// Rotates (vec_x, vec_y, vec_z), signed Q16.16, by angle_deg whole degrees about
// the axis quaternion held in the csr_ registers, and returns the saturated
// rotated vector plus a degenerate flag (set, with a zero vector, when the
// rotation quaternion has zero norm).
// req_ channel: one word per vector, valid/ready. rsp_ channel: one word per
// request, in order, valid/ready. csr_: APB-style, word registers axis_w at 0x0,
// axis_x at 0x4, axis_y at 0x8, axis_z at 0xC, pready tied high.
// Throughput: one word per cycle while neither the receiver nor the normalizer holds
// the flow. A word passes the 10-stage rotation datapath, the 33-stage divide by |r|^2
// (one quotient bit per stage after the first) and the output register.
// After reset, and after each csr write, the axis normalizer runs a sequence
// (square sums, 32-step square root, three 60-step divides); req_ready stays low
// for its duration.
// When the receiver stalls, the pipeline keeps moving as long as its last stage
// holds no word; a word in the last stage waits behind the output register and
// the whole pipeline holds with it, dropping nothing.
module quaternion_vector_rotator #(
   parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [15:0] req_angle_deg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_degenerate
);
   import qvr_pkg::*;

   localparam int FRONT = 10;
   localparam int DEPTH = FRONT + DIV_STAGES + 1;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // ---------------- configuration ----------------
   logic signed [31:0] axis_w_ff, axis_x_ff, axis_y_ff, axis_z_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_w_ff <= AXIS_W_RST;
         axis_x_ff <= '0;
         axis_y_ff <= '0;
         axis_z_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_AXIS_W: axis_w_ff <= csr_pwdata;
            REG_AXIS_X: axis_x_ff <= csr_pwdata;
            REG_AXIS_Y: axis_y_ff <= csr_pwdata;
            REG_AXIS_Z: axis_z_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_AXIS_W: csr_prdata = axis_w_ff;
         REG_AXIS_X: csr_prdata = axis_x_ff;
         REG_AXIS_Y: csr_prdata = axis_y_ff;
         REG_AXIS_Z: csr_prdata = axis_z_ff;
         default:    csr_prdata = '0;
      endcase
   end

   // Normalized axis (Q30) is rebuilt whenever a register changes.
   logic               norm_busy;
   logic signed [31:0] n_axis [3];

   qvr_axis_norm #(
      .FRAC_BITS(FRAC_BITS)
   ) u_axis_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_wr),
      .axis_w (axis_w_ff),
      .axis_x (axis_x_ff),
      .axis_y (axis_y_ff),
      .axis_z (axis_z_ff),
      .busy   (norm_busy),
      .n_x    (n_axis[0]),
      .n_y    (n_axis[1]),
      .n_z    (n_axis[2])
   );

   // ---------------- flow control ----------------
   // Advance the whole pipe unless a finished word would overrun a held result.
   logic [DEPTH-1:0] vld_ff;
   logic             adv;
   logic             accept;
   logic             rsp_valid_ff;

   assign adv       = rsp_ready | ~rsp_valid_ff | ~vld_ff[DEPTH-1];
   assign req_ready = adv & ~norm_busy;
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], accept};
      end
   end

   // Input vector travels alongside the angle and rotation stages until the last product.
   logic signed [31:0] vec_d_ff [1:8][3];

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_d_ff[1][0] <= req_vec_x;
         vec_d_ff[1][1] <= req_vec_y;
         vec_d_ff[1][2] <= req_vec_z;
         for (int k = 2; k <= 8; k++) vec_d_ff[k] <= vec_d_ff[k-1];
      end
   end

   // ---------------- stages 1-5: half-angle cos/sin ----------------
   logic [16:0]        ang1_ff, ang2_ff;
   logic [33:0]        prod2_ff;
   logic [9:0]         rem3_ff;
   logic [1:0]         quad4_ff;
   logic [6:0]         idx4_ff;
   logic               swap4_ff;
   logic signed [31:0] w5_ff, s5_ff;

   logic [16:0]        rem_raw;
   logic [9:0]         rem3_in;
   logic [1:0]         quad4_in;
   logic [7:0]         r4;
   logic [6:0]         idx4_in;
   logic signed [31:0] sp, cp, s0v, c0v, w5_in, s5_in;

   // rem_raw < 1440: the reciprocal estimate is low by at most one
   assign rem_raw = ang2_ff - 17'(prod2_ff[33:RECIP_SHIFT]) * MOD_720;
   assign rem3_in = (rem_raw >= MOD_720) ? 10'(rem_raw - MOD_720) : rem_raw[9:0];

   always_comb begin
      if (rem3_ff >= 10'd540) begin
         quad4_in = QUAD_3;
         r4       = 8'(rem3_ff - 10'd540);
      end else if (rem3_ff >= 10'd360) begin
         quad4_in = QUAD_2;
         r4       = 8'(rem3_ff - 10'd360);
      end else if (rem3_ff >= 10'd180) begin
         quad4_in = QUAD_1;
         r4       = 8'(rem3_ff - 10'd180);
      end else begin
         quad4_in = QUAD_0;
         r4       = rem3_ff[7:0];
      end
      idx4_in = (r4 <= 8'd90) ? r4[6:0] : 7'(8'd180 - r4);
   end

   always_comb begin
      sp  = $signed({1'b0, SIN_TAB[idx4_ff]});
      cp  = $signed({1'b0, COS_TAB[idx4_ff]});
      s0v = swap4_ff ? cp : sp;
      c0v = swap4_ff ? sp : cp;
      case (quad4_ff)
         QUAD_0: begin w5_in = c0v;  s5_in = s0v;  end
         QUAD_1: begin w5_in = -s0v; s5_in = c0v;  end
         QUAD_2: begin w5_in = -c0v; s5_in = -s0v; end
         QUAD_3: begin w5_in = s0v;  s5_in = -c0v; end
         default: begin w5_in = c0v; s5_in = s0v; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang1_ff  <= {1'b0, ~req_angle_deg[15], req_angle_deg[14:0]} + ANGLE_OFS;
         prod2_ff <= 34'(ang1_ff) * 34'(RECIP_720);
         ang2_ff  <= ang1_ff;
         rem3_ff  <= rem3_in;
         quad4_ff <= quad4_in;
         idx4_ff  <= idx4_in;
         swap4_ff <= (r4 > 8'd90);
         w5_ff    <= w5_in;
         s5_ff    <= s5_in;
      end
   end

   // ---------------- stages 6-10: rotation arithmetic ----------------
   logic signed [31:0] w6_ff, w7_ff, w8_ff;
   logic signed [31:0] u6_ff [3];
   logic signed [31:0] u7_ff [3];
   logic signed [31:0] u8_ff [3];
   logic signed [63:0] ww7_ff;
   logic signed [63:0] uu7_ff [3];
   logic signed [63:0] uv7_ff [3][3];
   logic [30:0]        n28_8_ff, n28_9_ff, n28_10_ff;
   logic signed [31:0] a8_ff;
   logic signed [33:0] d8_ff;
   logic signed [33:0] cr8_ff [3];
   logic               dg9_ff, dg10_ff;
   logic signed [63:0] av9_ff  [3];
   logic signed [63:0] du9_ff  [3];
   logic signed [63:0] wcr9_ff [3];
   logic signed [63:0] num10_ff [3];

   logic signed [63:0] su_prod [3];
   logic signed [63:0] ww7_in;
   logic signed [63:0] uu7_in [3];
   logic signed [63:0] uv7_in [3][3];
   logic signed [63:0] sumsq, usum, diffa, dotp;
   logic signed [63:0] crd [3];
   logic signed [65:0] du_full [3];
   logic signed [65:0] wcr_full [3];
   logic signed [63:0] av9_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         su_prod[i] = s5_ff * n_axis[i];
         uu7_in[i]  = u6_ff[i] * u6_ff[i];
         for (int j = 0; j < 3; j++) uv7_in[i][j] = u6_ff[i] * vec_d_ff[6][j];
      end
      ww7_in = w6_ff * w6_ff;
      usum   = uu7_ff[0] + uu7_ff[1] + uu7_ff[2];
      sumsq  = ww7_ff + usum;
      diffa  = ww7_ff - usum;
      dotp   = uv7_ff[0][0] + uv7_ff[1][1] + uv7_ff[2][2];
      crd[0] = uv7_ff[1][2] - uv7_ff[2][1];
      crd[1] = uv7_ff[2][0] - uv7_ff[0][2];
      crd[2] = uv7_ff[0][1] - uv7_ff[1][0];
      for (int i = 0; i < 3; i++) begin
         av9_in[i]   = a8_ff * vec_d_ff[8][i];
         du_full[i]  = d8_ff * u8_ff[i];
         wcr_full[i] = w8_ff * cr8_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 6: u = s * n
         for (int i = 0; i < 3; i++) u6_ff[i] <= su_prod[i][61:30];
         w6_ff <= w5_ff;
         // stage 7: w^2, the squares of u and all products of u and v
         ww7_ff <= ww7_in;
         uu7_ff <= uu7_in;
         uv7_ff <= uv7_in;
         w7_ff  <= w6_ff;
         u7_ff  <= u6_ff;
         // stage 8: |r|^2 in Q28, w^2-|u|^2, u.v and u x v
         n28_8_ff <= sumsq[62:32];
         a8_ff    <= diffa[61:30];
         d8_ff    <= dotp[63:30];
         for (int i = 0; i < 3; i++) cr8_ff[i] <= crd[i][63:30];
         w8_ff    <= w7_ff;
         u8_ff    <= u7_ff;
         // stage 9: scale terms
         av9_ff   <= av9_in;
         for (int i = 0; i < 3; i++) begin
            du9_ff[i]  <= du_full[i][63:0];
            wcr9_ff[i] <= wcr_full[i][63:0];
         end
         n28_9_ff <= n28_8_ff;
         dg9_ff   <= (n28_8_ff == '0);
         // stage 10: numerator
         for (int i = 0; i < 3; i++) begin
            num10_ff[i] <= (av9_ff[i] >>> 2) + ((du9_ff[i] >>> 2) <<< 1)
                           - ((wcr9_ff[i] >>> 2) <<< 1);
         end
         n28_10_ff <= n28_9_ff;
         dg10_ff   <= dg9_ff;
      end
   end

   // ---------------- divide by |r|^2 ----------------
   logic signed [31:0] quot [3];
   logic [DIV_STAGES:0] dg_d_ff;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      qvr_div_lane u_div (
         .clock  (clock),
         .enable (adv),
         .num    (num10_ff[i]),
         .den    (n28_10_ff),
         .quot   (quot[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dg_d_ff <= {dg_d_ff[DIV_STAGES-1:0], dg10_ff};
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[DEPTH-1] | (rsp_valid_ff & ~rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[DEPTH-1]) begin
         rsp_out_x      <= dg_d_ff[DIV_STAGES] ? '0 : quot[0];
         rsp_out_y      <= dg_d_ff[DIV_STAGES] ? '0 : quot[1];
         rsp_out_z      <= dg_d_ff[DIV_STAGES] ? '0 : quot[2];
         rsp_degenerate <= dg_d_ff[DIV_STAGES];
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/qvr_axis_norm.sv]
module qvr_axis_norm #(
   parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] axis_w,
   input  logic signed [31:0] axis_x,
   input  logic signed [31:0] axis_y,
   input  logic signed [31:0] axis_z,
   output logic               busy,
   output logic signed [31:0] n_x,
   output logic signed [31:0] n_y,
   output logic signed [31:0] n_z
);
   import qvr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_SQ1   = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_SQ2   = 3'd5;
   localparam logic [2:0] ST_ROOT  = 3'd6;
   localparam logic [2:0] ST_DIV   = 3'd7;

   localparam logic [63:0] SMALL_LIM = (64'd1 << (2 * FRAC_BITS)) / 64'd1000;
   localparam logic [31:0] MAG_HI    = 32'd1 << 30;
   localparam logic [31:0] MAG_LO    = 32'd1 << 29;
   localparam logic [5:0]  SQ_LAST   = 6'd4;
   localparam logic [5:0]  DIV_LAST  = 6'd59;
   localparam logic [1:0]  COMP_LAST = 2'd2;

   logic [2:0]         state_ff, state_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [1:0]         comp_ff, comp_in;
   logic [31:0]        m_ff [4];
   logic [31:0]        m_in [4];
   logic [3:0]         sgn_ff, sgn_in;
   logic [31:0]        mx_ff, mx_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        sum_ff, sum_in;
   logic [63:0]        rv_ff, rv_in;
   logic [63:0]        res_ff, res_in;
   logic [63:0]        bit_ff, bit_in;
   logic [59:0]        dvd_ff, dvd_in;
   logic [30:0]        drem_ff, drem_in;
   logic [30:0]        quot_ff, quot_in;
   logic signed [31:0] n_ff [3];
   logic signed [31:0] n_in [3];

   logic [31:0]        mag [4];
   logic [31:0]        mx01, mx23;
   logic [63:0]        trial;
   logic [31:0]        rem2;
   logic [32:0]        diff;
   logic               ge;
   logic [63:0]        sum_full;

   assign mag[0] = axis_w[31] ? 32'(-axis_w) : 32'(axis_w);
   assign mag[1] = axis_x[31] ? 32'(-axis_x) : 32'(axis_x);
   assign mag[2] = axis_y[31] ? 32'(-axis_y) : 32'(axis_y);
   assign mag[3] = axis_z[31] ? 32'(-axis_z) : 32'(axis_z);
   assign mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
   assign mx23 = (mag[2] > mag[3]) ? mag[2] : mag[3];

   assign sum_full = sum_ff + prod_ff;
   assign trial    = res_ff + bit_ff;
   assign rem2     = {drem_ff, dvd_ff[59]};
   assign diff     = {1'b0, rem2} - {1'b0, res_ff[31:0]};
   assign ge       = ~diff[32];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      m_in     = m_ff;
      sgn_in   = sgn_ff;
      mx_in    = mx_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      rv_in    = rv_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      dvd_in   = dvd_ff;
      drem_in  = drem_ff;
      quot_in  = quot_ff;
      n_in     = n_ff;
      case (state_ff)
         ST_LOAD: begin
            m_in     = mag;
            sgn_in   = {axis_z[31], axis_y[31], axis_x[31], axis_w[31]};
            mx_in    = (mx01 > mx23) ? mx01 : mx23;
            cnt_in   = '0;
            sum_in   = '0;
            state_in = ST_SQ1;
         end
         ST_SQ1, ST_SQ2: begin
            // square the head entry, rotate the set, accumulate each registered square on the next cycle
            if (cnt_ff != SQ_LAST) begin
               prod_in = 64'(m_ff[0]) * 64'(m_ff[0]);
               m_in[0] = m_ff[1];
               m_in[1] = m_ff[2];
               m_in[2] = m_ff[3];
               m_in[3] = m_ff[0];
               cnt_in  = cnt_ff + 6'd1;
            end
            if (cnt_ff != '0) begin
               sum_in = sum_full;
            end
            if (cnt_ff == SQ_LAST) begin
               if (state_ff == ST_SQ1) begin
                  state_in = ST_CHECK;
               end else begin
                  rv_in    = sum_full;
                  res_in   = '0;
                  bit_in   = 64'd1 << 62;
                  state_in = ST_ROOT;
               end
            end
         end
         ST_CHECK: begin
            if (mx_ff >= MAG_HI || sum_ff > SMALL_LIM) begin
               state_in = ST_SHIFT;
            end else begin
               n_in[0]  = '0;
               n_in[1]  = '0;
               n_in[2]  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (mx_ff >= MAG_HI) begin
               for (int i = 0; i < 4; i++) m_in[i] = m_ff[i] >> 1;
               mx_in = mx_ff >> 1;
            end else if (mx_ff < MAG_LO) begin
               for (int i = 0; i < 4; i++) m_in[i] = m_ff[i] << 1;
               mx_in = mx_ff << 1;
            end else begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_SQ2;
            end
         end
         ST_ROOT: begin
            if (rv_ff >= trial) begin
               rv_in  = rv_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               comp_in  = '0;
               cnt_in   = '0;
               dvd_in   = {m_ff[1][29:0], 30'd0};
               drem_in  = '0;
               quot_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            drem_in = ge ? diff[30:0] : rem2[30:0];
            dvd_in  = {dvd_ff[58:0], 1'b0};
            quot_in = {quot_ff[29:0], ge};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               n_in[comp_ff] = sgn_ff[1] ? -$signed({1'b0, quot_in}) : $signed({1'b0, quot_in});
               m_in[0] = m_ff[1];
               m_in[1] = m_ff[2];
               m_in[2] = m_ff[3];
               m_in[3] = m_ff[0];
               sgn_in  = {sgn_ff[0], sgn_ff[3:1]};
               dvd_in  = {m_ff[2][29:0], 30'd0};
               drem_in = '0;
               quot_in = '0;
               cnt_in  = '0;
               comp_in = comp_ff + 2'd1;
               if (comp_ff == COMP_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (start) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      sgn_ff  <= sgn_in;
      mx_ff   <= mx_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rv_ff   <= rv_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      dvd_ff  <= dvd_in;
      drem_ff <= drem_in;
      quot_ff <= quot_in;
      n_ff    <= n_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign n_x  = n_ff[0];
   assign n_y  = n_ff[1];
   assign n_z  = n_ff[2];

endmodule

[design/qvr_div_lane.sv]
module qvr_div_lane (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [63:0] num,
   input  logic [30:0]        den,
   output logic signed [31:0] quot
);
   import qvr_pkg::*;

   logic [30:0] rem_ff [0:DIV_STAGES];
   logic [31:0] lq_ff  [0:DIV_STAGES];
   logic [30:0] den_ff [0:DIV_STAGES];
   logic        neg_ff [0:DIV_STAGES];
   logic        ovf_ff [0:DIV_STAGES];

   logic [63:0] mag;
   logic [31:0] q;

   assign mag = num[63] ? 64'(-num) : 64'(num);

   // quotient of 2^32 or more saturates; otherwise the high word is the first remainder
   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff[0] <= num[63];
         ovf_ff[0] <= (mag[63:32] >= {1'b0, den});
         rem_ff[0] <= mag[62:32];
         lq_ff[0]  <= mag[31:0];
         den_ff[0] <= den;
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
      logic [31:0] rem2;
      logic [32:0] diff;
      logic        ge;

      assign rem2 = {rem_ff[k-1], lq_ff[k-1][31]};
      assign diff = {1'b0, rem2} - {2'b00, den_ff[k-1]};
      assign ge   = ~diff[32];

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= ge ? diff[30:0] : rem2[30:0];
            lq_ff[k]  <= {lq_ff[k-1][30:0], ge};
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign q = lq_ff[DIV_STAGES];

   always_comb begin
      if (ovf_ff[DIV_STAGES]) begin
         quot = neg_ff[DIV_STAGES] ? SAT_MIN : SAT_MAX;
      end else if (neg_ff[DIV_STAGES]) begin
         quot = (q > 32'h8000_0000) ? SAT_MIN : $signed(-q);
      end else begin
         quot = q[31] ? SAT_MAX : $signed(q);
      end
   end

endmodule

[dv/tb.sv]
module tb;
   import qvr_pkg::*;

   localparam int         FRAC = 16;
   localparam int         PIPE_LATENCY = 44;
   // The normalizer keeps req_ready low for its whole sequence after a write, and the receiver
   // may hold off in the back-pressure test, so allow several times the longer of the two.
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] HALF_DEG_Q30 = 64'd9370165;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               degenerate;
   } rotated_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [3:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   logic req_valid, req_ready;
   logic signed [31:0] req_vec_x, req_vec_y, req_vec_z;
   logic signed [15:0] req_angle_deg;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_degenerate;

   // Axis registers as written, and the unit axis derived from them (Q30)
   logic [31:0] axis_reg [4];
   longint      unit_axis [3];

   rotated_type rotated_q[$];
   int  error_count = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  degenerate_seen = 0;
   int  axis_settings = 0;
   int  idle_cycles = 0;
   bit  hold_receiver = 0;
   bit  no_idle = 0;

   quaternion_vector_rotator DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- predictor ----------------

   function automatic logic [63:0] taylor_sin(input logic [63:0] x);
      logic [63:0] x2, t;
      x2 = (x * x) >> 30;
      t = Q30_ONE - x2 / 72;
      t = Q30_ONE - ((x2 * t) >> 30) / 42;
      t = Q30_ONE - ((x2 * t) >> 30) / 20;
      t = Q30_ONE - ((x2 * t) >> 30) / 6;
      return (x * t) >> 30;
   endfunction

   function automatic logic [63:0] taylor_cos(input logic [63:0] x);
      logic [63:0] x2, t;
      x2 = (x * x) >> 30;
      t = Q30_ONE - x2 / 56;
      t = Q30_ONE - ((x2 * t) >> 30) / 30;
      t = Q30_ONE - ((x2 * t) >> 30) / 12;
      t = Q30_ONE - ((x2 * t) >> 30) / 2;
      return t;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Recompute the unit axis after any register change
   function automatic void update_unit_axis();
      longint      comp [4];
      logic [63:0] mag [4];
      logic [63:0] mx, sum, root, q;
      bit          usable;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         comp[i] = longint'(signed'(axis_reg[i]));
         mag[i] = comp[i] < 0 ? 64'(-comp[i]) : 64'(comp[i]);
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx >= Q30_ONE) begin
         usable = 1;
      end else begin
         for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
         usable = sum > ((64'd1 << (2 * FRAC)) / 1000);
      end
      if (!usable) begin
         for (int i = 0; i < 3; i++) unit_axis[i] = 0;
         return;
      end
      // Bring the largest magnitude into [2^29, 2^30)
      while (mx >= Q30_ONE) begin
         for (int i = 0; i < 4; i++) mag[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (Q30_ONE >> 1)) begin
         for (int i = 0; i < 4; i++) mag[i] <<= 1;
         mx <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
      root = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i+1] << 30) / root;
         unit_axis[i] = comp[i+1] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > longint'(SAT_MAX)) return SAT_MAX;
      if (v < longint'(SAT_MIN)) return SAT_MIN;
      return v[31:0];
   endfunction

   function automatic rotated_type rotate_vector(input logic signed [31:0] vx, vy, vz,
                                                input logic signed [15:0] angle);
      rotated_type res;
      int          t, quad, rem;
      logic [63:0] arg, n28;
      longint      c0, s0, w, s, a, d, num;
      longint      v [3];
      longint      u [3];
      longint      cr [3];
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      // Half angle in half-degree steps, folded into one octant
      t = int'(angle) % 720;
      if (t < 0) t += 720;
      quad = t / 180;
      rem = t % 180;
      if (rem <= 90) begin
         arg = 64'(rem) * HALF_DEG_Q30;
         s0 = longint'(taylor_sin(arg));
         c0 = longint'(taylor_cos(arg));
      end else begin
         arg = 64'(180 - rem) * HALF_DEG_Q30;
         s0 = longint'(taylor_cos(arg));
         c0 = longint'(taylor_sin(arg));
      end
      case (quad)
         0: begin w = c0; s = s0; end
         1: begin w = -s0; s = c0; end
         2: begin w = -c0; s = -s0; end
         default: begin w = s0; s = -c0; end
      endcase
      for (int i = 0; i < 3; i++) u[i] = (s * unit_axis[i]) >>> 30;
      n28 = (64'(w * w) + 64'(u[0] * u[0]) + 64'(u[1] * u[1]) + 64'(u[2] * u[2])) >> 32;
      res = '0;
      if (n28 == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      a = (w * w - (u[0] * u[0] + u[1] * u[1] + u[2] * u[2])) >>> 30;
      d = (u[0] * v[0] + u[1] * v[1] + u[2] * v[2]) >>> 30;
      cr[0] = (u[1] * v[2] - u[2] * v[1]) >>> 30;
      cr[1] = (u[2] * v[0] - u[0] * v[2]) >>> 30;
      cr[2] = (u[0] * v[1] - u[1] * v[0]) >>> 30;
      for (int i = 0; i < 3; i++) begin
         num = ((a * v[i]) >>> 2) + 2 * ((d * u[i]) >>> 2) - 2 * ((w * cr[i]) >>> 2);
         num = num / longint'(n28);
         case (i)
            0: res.x = clamp32(num);
            1: res.y = clamp32(num);
            default: res.z = clamp32(num);
         endcase
      end
      return res;
   endfunction

   // ---------------- drivers ----------------

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one word, hold it until accepted, then maybe idle
   task automatic send_vector(input logic signed [31:0] vx, vy, vz,
                              input logic signed [15:0] angle);
      int gap;
      req_valid <= 1'b1;
      req_vec_x <= vx;
      req_vec_y <= vy;
      req_vec_z <= vz;
      req_angle_deg <= angle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rotated_q.push_back(rotate_vector(vx, vy, vz, angle));
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_axis(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      axis_reg[idx] = value;
      update_unit_axis();
   endtask

   task automatic set_axis(input logic [31:0] w, x, y, z);
      drain();
      write_axis(REG_AXIS_W, w);
      write_axis(REG_AXIS_X, x);
      write_axis(REG_AXIS_Y, y);
      write_axis(REG_AXIS_Z, z);
      axis_settings++;
   endtask

   function automatic logic signed [31:0] rand_component();
      case ($urandom_range(0, 5))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return $urandom();
         default: return signed'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 8) * 90);
         1: return 16'($urandom_range(0, 1440)) - 16'sd720;
         default: return 16'($urandom());
      endcase
   endfunction

   // ---------------- tests ----------------

   // Reset axis has no vector part: identity, except a half turn goes degenerate
   task automatic test_reset_axis();
      send_vector(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 16'sd0);
      send_vector(SAT_MAX, SAT_MIN, 32'sd0, 16'sd90);
      send_vector(32'sd5, -32'sd7, 32'sd9, 16'sd180);
      send_vector(SAT_MIN, SAT_MAX, SAT_MIN, -16'sd180);
      send_vector(32'sd1, 32'sd2, 32'sd3, 16'sd540);
      send_vector(32'sd1, 32'sd2, 32'sd3, 16'sh7FFF);
      send_vector(32'sd1, 32'sd2, 32'sd3, 16'sh8000);
   endtask

   // Axes along z and x, plus extreme registers and axes too small to use (all ones, all zero)
   task automatic test_directed_axes();
      set_axis(32'sd0, 32'sd0, 32'sd0, 32'sh0001_0000);
      send_vector(32'sh0001_0000, 32'sd0, 32'sd0, 16'sd90);
      send_vector(SAT_MAX, SAT_MAX, 32'sd0, 16'sd45);  // saturates
      send_vector(SAT_MIN, SAT_MIN, SAT_MAX, -16'sd45);
      send_vector(32'sd0, 32'sd0, 32'sd0, 16'sd359);
      send_vector(32'sh0001_0000, 32'sh0001_0000, 32'sd0, 16'sd720);
      send_vector(32'sh0001_0000, 32'sd7, 32'sd0, 16'sd719);
      set_axis(SAT_MAX, SAT_MIN, SAT_MAX, 32'sd1);
      send_vector(SAT_MAX, SAT_MIN, SAT_MAX, 16'sd120);
      send_vector(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 16'sd180);
      send_vector(SAT_MIN, SAT_MIN, SAT_MIN, 16'sh8000);
      set_axis(32'sd1, 32'sd1, 32'sd1, 32'sd1);  // below the small-axis floor
      send_vector(32'sh0001_0000, 32'sd0, 32'sd0, 16'sd180);
      send_vector(32'sh0001_0000, 32'sd0, 32'sd0, 16'sd60);
      set_axis(32'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_vector(32'sd3, 32'sd4, 32'sd5, 16'sd180);
      send_vector(32'sd3, 32'sd4, 32'sd5, 16'sd30);
      set_axis(32'sd0, -32'sh0004_0000, 32'sd0, 32'sd0);
      send_vector(32'sd0, 32'sh0001_0000, 32'sd0, 16'sd90);
      send_vector(32'sd0, 32'sh0001_0000, -32'sh0001_0000, -16'sd270);
   endtask

   // Stall the receiver long enough for the pipeline to fill and stop req_ready
   task automatic test_backpressure();
      hold_receiver = 1;
      no_idle = 1;
      for (int i = 0; i < 90; i++)
         send_vector(rand_component(), rand_component(), rand_component(), rand_angle());
      no_idle = 0;
   endtask

   // Sender pauses until every word is back, then resumes
   task automatic test_drain_pause();
      for (int i = 0; i < 20; i++)
         send_vector(rand_component(), rand_component(), rand_component(), rand_angle());
      drain();
      for (int i = 0; i < 20; i++)
         send_vector(rand_component(), rand_component(), rand_component(), rand_angle());
   endtask

   task automatic test_random_axes(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         if (p % 3 == 0)
            set_axis(rand_component(), rand_component(), rand_component(), rand_component());
         else
            set_axis($urandom(), $urandom(), $urandom(), $urandom());
         no_idle = (p == 1);
         for (int i = 0; i < per_phase; i++)
            send_vector(rand_component(), rand_component(), rand_component(), rand_angle());
      end
      no_idle = 0;
   endtask

   // ---------------- receiver, checker, watchdog ----------------

   initial begin
      int len;
      rsp_ready = 1'b0;
      forever begin
         if (hold_receiver) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_receiver = 0;
         end else if (no_idle || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            len = $urandom_range(1, 20);
            repeat (len) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
            repeat (len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rotated_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rotated_q.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            want = rotated_q.pop_front();
            words_checked++;
            if (want.degenerate) degenerate_seen++;
            if (rsp_out_x !== want.x) begin
               $error("out_x expected %0d got %0d", want.x, rsp_out_x);
               error_count++;
            end
            if (rsp_out_y !== want.y) begin
               $error("out_y expected %0d got %0d", want.y, rsp_out_y);
               error_count++;
            end
            if (rsp_out_z !== want.z) begin
               $error("out_z expected %0d got %0d", want.z, rsp_out_z);
               error_count++;
            end
            if (rsp_degenerate !== want.degenerate) begin
               $error("degenerate expected %0b got %0b", want.degenerate, rsp_degenerate);
               error_count++;
            end
         end
      end
   end

   // Count cycles with no handshake on any port; give up at the limit
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_valid = 1'b0;
      req_vec_x = '0;
      req_vec_y = '0;
      req_vec_z = '0;
      req_angle_deg = '0;
      axis_reg[REG_AXIS_W] = AXIS_W_RST;
      axis_reg[REG_AXIS_X] = '0;
      axis_reg[REG_AXIS_Y] = '0;
      axis_reg[REG_AXIS_Z] = '0;
      update_unit_axis();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_axis();
      test_directed_axes();
      test_backpressure();
      test_drain_pause();
      test_random_axes(6, 130);

      drain();
      $display("Checked %0d of %0d rotated words (%0d degenerate) over %0d axis settings.",
               words_checked, words_sent, degenerate_seen, axis_settings);
      $display("Covered angle wrap, small and extreme axes, saturation and back-pressure.");
      if (error_count == 0 && rotated_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
